/* src/tmtw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg
// types and constants shared by the text-mode terminal writer
// ----------------------------------------------------------------------------
package tmtw_pkg;

    // field widths fixed by the request and response formats
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = 16;
    localparam int CELL_INDEX_W = 11;
    localparam int OUT_ROW_W    = 5;
    localparam int OUT_COL_W    = 7;

    // request kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

    // command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // request and response payloads
    typedef struct packed {
        logic                    kind;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_column;
    } t_rsp;

    // classified command
    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_READ_NONE
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_cmd;

    // back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_back_status;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_REPLY
    } t_state;

endpackage : tmtw_pkg
`default_nettype wire

/* src/tmtw_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_front
// accepts requests and classifies them into commands for the queue
// ----------------------------------------------------------------------------
module tmtw_front #(
    parameter int CELL_COUNT = 2000
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_req_valid,
    output logic                       o_req_stall,
    input  tmtw_pkg::t_req             i_req_item,
    input  wire                        i_q_full,
    input  tmtw_pkg::t_back_status     i_status,
    output logic                       o_push,
    output tmtw_pkg::t_cmd             o_cmd
);
    import tmtw_pkg::*;

    logic in_range;
    logic r_seen_clear;

    // hold requests off while the queue is full or the screen is being cleared
    assign o_req_stall = i_q_full | i_status.clearing | ~r_seen_clear;
    assign o_push      = i_req_valid & ~o_req_stall;

    // after reset, requests also wait until the back end raises its clearing flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_clear <= 1'b0;
        end else if (i_status.clearing) begin
            r_seen_clear <= 1'b1;
        end
    end

    // classify the request
    assign in_range = ({21'd0, i_req_item.cell_index} < 32'(CELL_COUNT));

    always_comb begin
        o_cmd.char_code  = i_req_item.char_code;
        o_cmd.cell_index = i_req_item.cell_index;
        if (i_req_item.kind == KIND_READ) begin
            o_cmd.op = in_range ? OP_READ : OP_READ_NONE;
        end else if (i_req_item.char_code == NEWLINE_CODE) begin
            o_cmd.op = OP_NEWLINE;
        end else begin
            o_cmd.op = OP_PUT;
        end
    end

endmodule : tmtw_front
`default_nettype wire

/* src/tmtw_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module tmtw_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  tmtw_pkg::t_cmd    i_push_cmd,
    output logic              o_full,
    output logic              o_valid,
    output tmtw_pkg::t_cmd    o_cmd,
    input  wire               i_pop
);
    import tmtw_pkg::*;

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule : tmtw_queue
`default_nettype wire

/* src/tmtw_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_back
// carries out commands on the screen memory and cursor, drives responses
// ----------------------------------------------------------------------------
module tmtw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire  [7:0]              i_cfg_wr_data,
    input  wire                     i_cmd_valid,
    input  tmtw_pkg::t_cmd          i_cmd,
    output logic                    o_cmd_pop,
    output tmtw_pkg::t_back_status  o_status,
    output logic                    o_rsp_valid,
    input  wire                     i_rsp_stall,
    output tmtw_pkg::t_rsp          o_rsp_item
);
    import tmtw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] SRC_FIRST  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] SRC_OFFSET = ADDR_W'(COLUMNS + 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

    // screen memory
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    // control and cursor state
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_rd_ok, n_rd_ok;
    logic [ATTR_W-1:0]  r_color;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               out_free;
    logic               out_load;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  cmd_addr;
    logic [CELL_W-1:0]  blank_cell;

    assign out_free   = ~r_out_valid | ~i_rsp_stall;
    assign cur_addr   = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS)) + ADDR_W'(r_col);
    assign cmd_addr   = ADDR_W'(i_cmd.cell_index);
    assign blank_cell = {r_color, SPACE_CODE};

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_rsp_valid       = r_out_valid;
    assign o_rsp_item        = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_ptr == LAST_CELL) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_NEWLINE && r_row == LAST_ROW) begin
                        n_state = ST_SCROLL;
                    end else begin
                        n_state = ST_REPLY;
                    end
                end
            end
            ST_SCROLL: begin
                if (r_ptr == LAST_COPY) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (r_ptr == LAST_CELL) begin
                    n_state = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls per state
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = r_ptr;
        mem_wd    = blank_cell;
        mem_re    = 1'b0;
        mem_ra    = cmd_addr;
        n_ptr     = r_ptr;
        n_row     = r_row;
        n_col     = r_col;
        n_rd_ok   = r_rd_ok;
        o_cmd_pop = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = RESET_CELL;
                n_ptr  = r_ptr + 1'b1;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_rd_ok   = 1'b0;
                    unique case (i_cmd.op)
                        OP_PUT: begin
                            mem_we = 1'b1;
                            mem_wa = cur_addr;
                            mem_wd = {r_color, i_cmd.char_code};
                            if (r_col == LAST_COL) begin
                                n_col = '0;
                                n_row = (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            n_col = '0;
                            if (r_row != LAST_ROW) begin
                                n_row = r_row + 1'b1;
                            end else begin
                                // prime the copy with the first cell of row one
                                mem_re = 1'b1;
                                mem_ra = SRC_FIRST;
                                n_ptr  = '0;
                            end
                        end
                        OP_READ: begin
                            mem_re  = 1'b1;
                            n_rd_ok = 1'b1;
                        end
                        OP_READ_NONE: begin
                            n_rd_ok = 1'b0;
                        end
                        default: n_rd_ok = 1'b0;
                    endcase
                end
            end
            ST_SCROLL: begin
                // write the cell read last cycle one row up, fetch the next
                mem_we = 1'b1;
                mem_wd = r_rdata;
                if (r_ptr != LAST_COPY) begin
                    mem_re = 1'b1;
                    mem_ra = r_ptr + SRC_OFFSET;
                end
                n_ptr = r_ptr + 1'b1;
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + 1'b1;
            end
            ST_REPLY: begin
                out_load = out_free;
            end
            default: n_ptr = r_ptr;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ptr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rd_ok <= n_rd_ok;
        end
    end

    // text colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    // screen memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.cell_value    <= r_rd_ok ? r_rdata : '0;
            r_out.cursor_row    <= OUT_ROW_W'(r_row);
            r_out.cursor_column <= OUT_COL_W'(r_col);
        end
    end

endmodule : tmtw_back
`default_nettype wire

/* src/text_mode_terminal_writer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// character-cell console: puts characters at a cursor, scrolls, reads cells
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen memory to blanks (space, light grey
// on black), one cell a cycle, and stalls requests until the sweep is done.
// An accepted request goes into a small queue and an idle back end takes it
// in the very next cycle. A put, a newline below the last row or a read then
// takes the back end from the idle state, which acts on the screen memory, to
// the reply state, which loads the response register once the output is free.
// The response thus passes through the queue, the idle state and the reply
// state, and the back end takes no new request until the reply is loaded. A
// newline on the last row scrolls the screen through the screen memory: it
// copies cells one row up, one read and one write a cycle, then blanks the
// last row in the current colour and goes to the reply state. Meanwhile the
// queue keeps taking up to two further requests. Every request gives one
// response with the cursor after it; cell_value is the cell read, or 0.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr_en,
    input  wire  [7:0]        i_cfg_wr_data,
    input  wire               i_req_valid,
    output logic              o_req_stall,
    input  tmtw_pkg::t_req    i_req_item,
    output logic              o_rsp_valid,
    input  wire               i_rsp_stall,
    output tmtw_pkg::t_rsp    o_rsp_item
);
    import tmtw_pkg::*;

    logic         q_full;
    logic         q_valid;
    logic         push;
    logic         pop;
    t_cmd         push_cmd;
    t_cmd         head_cmd;
    t_back_status status;

    // front end: request intake and classification
    tmtw_front #(
        .CELL_COUNT (ROWS * COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req_item  (i_req_item),
        .i_q_full    (q_full),
        .i_status    (status),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // command queue
    tmtw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (head_cmd),
        .i_pop      (pop)
    );

    // back end: screen memory, cursor and responses
    tmtw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_cmd_pop     (pop),
        .o_status      (status),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp_item    (o_rsp_item)
    );

    // no request gets in while the screen is being cleared
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !push)
        else $error("request accepted during screen clear");

    // the queue is never pushed while full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("push into full command queue");

    // a fresh response carries a column within the line
    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !$past(o_rsp_valid && i_rsp_stall)) |->
            (32'(o_rsp_item.cursor_column) < COLUMNS))
        else $error("cursor column beyond line");

endmodule : text_mode_terminal_writer
`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text-mode terminal writer
// ----------------------------------------------------------------------------
// Runs a short table of directed requests (reset screen, field extremes,
// out-of-range reads, newline, scroll on the last row), then three random
// phases built from lines of text of random length with reads mixed in. The
// colour register changes between phases. A shadow copy of the screen and
// cursor predicts each reply the table does not give; replies are checked in
// order. Both sides throttle at random, the receiver holds off once for a long
// stretch, and the sender pauses once mid-phase until every reply is back.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmtw_pkg::*;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int HALF_PERIOD  = 5;
    localparam int RUN_LIMIT    = 1_500_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SCROLL_CAP   = 80;
    localparam int PHASE_ITEMS  = 500;
    localparam int PLAN_LEN     = 17;

    // one row of the directed plan, repeated reps times
    typedef struct packed {
        t_req       req;
        logic [7:0] reps;
        logic       typed;
        t_rsp       want;
    } t_step;

    localparam t_step PLAN [0:PLAN_LEN-1] = '{
        // reset screen and out-of-range reads
        '{'{KIND_READ, 8'h00, 11'd0},    8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0}},
        '{'{KIND_READ, 8'h00, 11'd1999}, 8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0}},
        '{'{KIND_READ, 8'h00, 11'd2000}, 8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0}},
        '{'{KIND_READ, 8'hFF, 11'd2047}, 8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0}},
        // character extremes in the reset colour
        '{'{KIND_PUT,  8'h00, 11'd2047}, 8'd1,  1'b1, '{16'h0000, 5'd0,  7'd1}},
        '{'{KIND_PUT,  8'hFF, 11'd0},    8'd1,  1'b1, '{16'h0000, 5'd0,  7'd2}},
        '{'{KIND_READ, 8'h00, 11'd0},    8'd1,  1'b1, '{16'h0700, 5'd0,  7'd2}},
        '{'{KIND_READ, 8'h00, 11'd1},    8'd1,  1'b1, '{16'h07FF, 5'd0,  7'd2}},
        '{'{KIND_PUT,  NEWLINE_CODE, 11'd0}, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0}},
        // walk down to the last row, then scroll once
        '{'{KIND_PUT,  8'h41, 11'd0},    8'd1,  1'b0, '0},
        '{'{KIND_PUT,  NEWLINE_CODE, 11'd0}, 8'd23, 1'b0, '0},
        '{'{KIND_PUT,  8'h42, 11'd0},    8'd1,  1'b0, '0},
        '{'{KIND_PUT,  NEWLINE_CODE, 11'd0}, 8'd1, 1'b0, '0},
        '{'{KIND_READ, 8'h00, 11'd1920}, 8'd1,  1'b0, '0},
        '{'{KIND_READ, 8'h00, 11'd1999}, 8'd1,  1'b0, '0},
        '{'{KIND_READ, 8'h00, 11'd0},    8'd1,  1'b0, '0},
        '{'{KIND_READ, 8'h00, 11'd1840}, 8'd1,  1'b0, '0}
    };

    logic i_clk         = 1'b0;
    logic i_rst_n       = 1'b0;
    logic i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic i_req_valid   = 1'b0;
    t_req i_req_item    = '0;
    logic i_rsp_stall   = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp_item;

    // shadow of the console
    logic [CELL_W-1:0] shadow_screen [SCREEN_CELLS];
    logic [ATTR_W-1:0] shadow_colour;
    int                cur_row;
    int                cur_col;
    int                scroll_count;
    int                line_left;

    // replies still owed by the block, oldest first
    t_rsp screen_replies_q [$];

    int          send_idle_pct = 0;
    int          rsp_idle_pct  = 0;
    int          mismatches    = 0;
    int unsigned cycle_count   = 0;
    logic        hold_ask      = 1'b0;
    logic        hold_done     = 1'b0;
    int          hold_left     = 0;

    text_mode_terminal_writer #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req_item    (i_req_item),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp_item    (o_rsp_item)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // apply one request to the shadow console and return its reply
    function automatic t_rsp console_step(input t_req r);
        t_rsp o;
        int   i;
        o = '0;
        if (r.kind == KIND_PUT) begin
            if (r.char_code == NEWLINE_CODE) begin
                cur_col = 0;
                if (cur_row < SCREEN_ROWS - 1) begin
                    cur_row++;
                end else begin
                    for (i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                        shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
                    for (i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                        shadow_screen[i] = {shadow_colour, SPACE_CODE};
                    scroll_count++;
                end
            end else begin
                shadow_screen[cur_row * SCREEN_COLS + cur_col] = {shadow_colour, r.char_code};
                cur_col++;
                if (cur_col >= SCREEN_COLS) begin
                    cur_col = 0;
                    cur_row++;
                    if (cur_row >= SCREEN_ROWS)
                        cur_row = 0;
                end
            end
        end else if (r.cell_index < SCREEN_CELLS) begin
            o.cell_value = shadow_screen[r.cell_index];
        end
        o.cursor_row    = cur_row[OUT_ROW_W-1:0];
        o.cursor_column = cur_col[OUT_COL_W-1:0];
        return o;
    endfunction

    // random request: mostly lines of text ending in a newline, some reads,
    // a little noise
    function automatic t_req pick_request();
        t_req r;
        int   pick;
        int   sel;
        r.kind       = KIND_PUT;
        r.char_code  = 8'($urandom_range(255));
        r.cell_index = 11'($urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < 4) begin
            r.kind = 1'($urandom_range(1));
        end else if (pick < 22) begin
            r.kind = KIND_READ;
            sel = $urandom_range(3);
            if (sel == 0)
                r.cell_index = 11'(SCREEN_CELLS + $urandom_range(2047 - SCREEN_CELLS));
            else if (sel == 1)
                r.cell_index = 11'($urandom_range(SCREEN_CELLS - 1));
            else
                r.cell_index = 11'((cur_row * SCREEN_COLS + cur_col + SCREEN_CELLS - 1
                                    - $urandom_range(3)) % SCREEN_CELLS);
        end else if (line_left == 0) begin
            r.char_code = NEWLINE_CODE;
            line_left = ($urandom_range(5) == 0) ? $urandom_range(60, 170)
                                                 : $urandom_range(0, 15);
        end else begin
            line_left--;
            if (r.char_code == NEWLINE_CODE)
                r.char_code = 8'h2E;
        end
        // keep the number of slow scrolls bounded
        if (r.kind == KIND_PUT && r.char_code == NEWLINE_CODE
                && cur_row == SCREEN_ROWS - 1 && scroll_count >= SCROLL_CAP)
            r.char_code = 8'h2A;
        return r;
    endfunction

    // offer one request and record its reply once it is taken
    task automatic offer(input t_req r, input logic typed, input t_rsp want);
        t_rsp predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req_item  <= r;
        do @(posedge i_clk); while (o_req_stall);
        predicted = console_step(r);
        screen_replies_q.push_back(typed ? want : predicted);
    endtask

    // stop sending until every reply is back
    task automatic drain();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (screen_replies_q.size() != 0);
    endtask

    task automatic write_colour(input logic [7:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        shadow_colour = v;
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int hold_at,
                             input int pause_at);
        t_req r;
        int   k;
        send_idle_pct = s_pct;
        rsp_idle_pct  = r_pct;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == pause_at)
                drain();
            if (k == hold_at)
                hold_ask <= 1'b1;
            r = pick_request();
            offer(r, 1'b0, '0);
        end
    endtask

    // receiver throttle, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_rsp_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_ask && !hold_done) begin
            i_rsp_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // reply checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (screen_replies_q.size() == 0) begin
                $display("%0t: reply with nothing pending, expected none got %h",
                         $time, o_rsp_item);
                mismatches++;
            end else begin
                want = screen_replies_q.pop_front();
                check_field("cell_value", 32'(want.cell_value),
                            32'(o_rsp_item.cell_value));
                check_field("cursor_row", 32'(want.cursor_row),
                            32'(o_rsp_item.cursor_row));
                check_field("cursor_column", 32'(want.cursor_column),
                            32'(o_rsp_item.cursor_column));
            end
        end
    end

    // main sequence
    initial begin
        int s;
        int k;
        for (k = 0; k < SCREEN_CELLS; k++)
            shadow_screen[k] = RESET_CELL;
        shadow_colour = RESET_COLOR;
        cur_row       = 0;
        cur_col       = 0;
        scroll_count  = 0;
        line_left     = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table in the reset colour
        send_idle_pct = 33;
        rsp_idle_pct  = 73;
        for (s = 0; s < PLAN_LEN; s++)
            for (k = 0; k < PLAN[s].reps; k++)
                offer(PLAN[s].req, PLAN[s].typed, PLAN[s].want);

        // random phases, colour changed while idle
        drain();
        write_colour(8'h00);
        run_phase(33, 73, -1, 250);
        drain();
        write_colour(8'hFF);
        run_phase(73, 33, -1, -1);
        drain();
        write_colour(8'($urandom_range(1, 254)));
        run_phase(0, 0, 100, -1);

        // wait out the last replies
        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && screen_replies_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire
